>>> hdl/handheld_bus_decoder_io_regs_assert.svh
// Assertion macros used by the checker file of the bus decoder.
`ifndef HANDHELD_BUS_DECODER_IO_REGS_ASSERT_SVH
`define HANDHELD_BUS_DECODER_IO_REGS_ASSERT_SVH
// Same-cycle implication, disabled while reset is low.
`define HBD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled while reset is low.
`define HBD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);
`endif

>>> hdl/hbd_pkg.sv
// Package with constants, codes and types of the bus decoder.
`default_nettype none
package hbd_pkg;
    localparam int ROM_BYTES  = 32768;
    localparam int OAM_BYTES  = 160;
    localparam int CART_AW    = $clog2(ROM_BYTES);
    localparam int BOOT_BYTES = 256;
    localparam int VRAM_BYTES = 8192;
    localparam int WRAM_BYTES = 8192;
    localparam int HRAM_BYTES = 127;
    localparam int CLR_AW     = 13;
    localparam logic [16:0] ROM_LIMIT = 17'(ROM_BYTES);

    localparam logic [2:0] ACT_READ    = 3'd0;
    localparam logic [2:0] ACT_WRITE   = 3'd1;
    localparam logic [2:0] ACT_LD_CART = 3'd2;
    localparam logic [2:0] ACT_LD_BOOT = 3'd3;
    localparam logic [2:0] ACT_POLL    = 3'd4;

    localparam logic [15:0] ADDR_DMA      = 16'hFF46;
    localparam logic [15:0] ADDR_BOOT_OFF = 16'hFF50;
    localparam logic [15:0] ADDR_ECHO     = 16'hE000;

    typedef struct packed {
        logic [2:0]  action;
        logic [15:0] address;
        logic [7:0]  write_data;
        logic        cpu_halted;
        logic        master_enable;
    } t_req;

    typedef struct packed {
        logic [7:0] read_data;
        logic       status;
        logic       wake;
        logic       irq_taken;
        logic [6:0] irq_vector;
    } t_rsp;

    typedef struct packed {
        logic clr;
        logic capture;
        logic exec;
        logic rd;
        logic rd_done;
        logic dma_start;
        logic dma_rd;
        logic dma_wr;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic is_read;
        logic is_dma;
        logic dma_last;
    } t_stat;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_EXEC, S_RDATA, S_DMA_RD, S_DMA_WR, S_FINISH
    } t_state;

    typedef enum logic [2:0] {
        RG_BOOT, RG_CART, RG_VRAM, RG_WRAM, RG_OAM, RG_HRAM, RG_REG, RG_ERR
    } t_region;
endpackage
`default_nettype wire

>>> hdl/hbd_if.sv
// Request and response channel interfaces of the bus decoder.
`default_nettype none
interface hbd_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  action;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic        cpu_halted;
    logic        master_enable;
    modport source (output valid, action, address, write_data, cpu_halted, master_enable,
                    input ready);
    modport sink (input valid, action, address, write_data, cpu_halted, master_enable,
                  output ready);
endinterface

interface hbd_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       status;
    logic       wake;
    logic       irq_taken;
    logic [6:0] irq_vector;
    modport source (output valid, read_data, status, wake, irq_taken, irq_vector,
                    input ready);
    modport sink (input valid, read_data, status, wake, irq_taken, irq_vector,
                  output ready);
endinterface
`default_nettype wire

>>> hdl/hbd_ctrl.sv
// Controller state machine that sequences clearing, requests and OAM DMA.
`default_nettype none
module hbd_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic          i_out_ready,
    input  wire hbd_pkg::t_stat i_stat,
    output hbd_pkg::t_cmd      o_cmd,
    output logic               o_in_ready,
    output logic               o_out_valid
);
    hbd_pkg::t_state r_state, n_state;
    logic r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hbd_pkg::S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        unique case (r_state)
            hbd_pkg::S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_stat.clr_last) n_state = hbd_pkg::S_IDLE;
            end
            hbd_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = hbd_pkg::S_EXEC;
                end
            end
            hbd_pkg::S_EXEC: begin
                priority if (i_stat.is_read) begin
                    o_cmd.rd = 1'b1;
                    n_state = hbd_pkg::S_RDATA;
                end else if (i_stat.is_dma) begin
                    o_cmd.dma_start = 1'b1;
                    n_state = hbd_pkg::S_DMA_RD;
                end else begin
                    o_cmd.exec = 1'b1;
                    n_state = hbd_pkg::S_FINISH;
                end
            end
            hbd_pkg::S_RDATA: begin
                o_cmd.rd_done = 1'b1;
                n_state = hbd_pkg::S_FINISH;
            end
            hbd_pkg::S_DMA_RD: begin
                o_cmd.dma_rd = 1'b1;
                n_state = hbd_pkg::S_DMA_WR;
            end
            hbd_pkg::S_DMA_WR: begin
                o_cmd.dma_wr = 1'b1;
                n_state = i_stat.dma_last ? hbd_pkg::S_FINISH : hbd_pkg::S_DMA_RD;
            end
            hbd_pkg::S_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid = 1'b1;
                    n_state = hbd_pkg::S_IDLE;
                end
            end
            default: n_state = hbd_pkg::S_CLEAR;
        endcase
    end

    assign o_out_valid = r_out_valid;
endmodule
`default_nettype wire

>>> hdl/hbd_datapath.sv
// Datapath with the memories, I/O registers, address decoder and result registers.
`default_nettype none
module hbd_datapath (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire hbd_pkg::t_cmd i_cmd,
    input  wire hbd_pkg::t_req i_req,
    output hbd_pkg::t_stat     o_stat,
    output hbd_pkg::t_rsp      o_rsp
);
    localparam int OAM_AW = $clog2(hbd_pkg::OAM_BYTES);
    localparam int CLR_W = hbd_pkg::CLR_AW;

    hbd_pkg::t_req r_req;
    hbd_pkg::t_rsp r_res, r_out, n_res;

    logic [7:0] cart_mem [hbd_pkg::ROM_BYTES];
    logic [7:0] boot_mem [hbd_pkg::BOOT_BYTES];
    logic [7:0] vram_mem [hbd_pkg::VRAM_BYTES];
    logic [7:0] wram_mem [hbd_pkg::WRAM_BYTES];
    logic [7:0] oam_mem  [hbd_pkg::OAM_BYTES];
    logic [7:0] hram_mem [hbd_pkg::HRAM_BYTES];
    logic [7:0] r_cart_q, r_boot_q, r_vram_q, r_wram_q, r_oam_q, r_hram_q;

    logic              r_overlay;
    logic [7:0]        r_joy, r_sc, r_if, r_ie;
    logic [7:0]        r_tmr [4];
    logic [7:0]        r_lcd [11];
    logic [CLR_W-1:0]  r_clr;
    logic [7:0]        r_dma_idx;
    logic              r_dma_bad;
    hbd_pkg::t_region  r_region, n_region;
    logic [7:0]        r_rval, n_rval;

    logic [15:0] rd_addr, wa;
    logic [7:0]  rd_byte, wd;
    logic        rd_err;
    logic        exec_wr, w_vram, w_wram, w_oam, w_hram, w_ie, w_joy, w_sc, w_tmr;
    logic        w_if, w_lcd, w_boot_off, w_err;
    logic [3:0]  rslot, wslot;
    logic [4:0]  pend;
    logic        taken;
    logic [2:0]  irq_num;

    logic               vram_we, wram_we, oam_we, hram_we;
    logic [CLR_W-1:0]   vram_wa, wram_wa;
    logic [OAM_AW-1:0]  oam_wa;
    logic [6:0]         hram_wa;
    logic [7:0]         vram_wd, wram_wd, oam_wd, hram_wd;
    logic               cart_we, boot_we;

    assign rd_addr = i_cmd.dma_rd ? {r_req.write_data, r_dma_idx} : r_req.address;
    assign wa      = r_req.address;
    assign wd      = r_req.write_data;
    assign exec_wr = i_cmd.exec && (r_req.action == hbd_pkg::ACT_WRITE);
    assign rslot   = (rd_addr[3:0] > 4'd6) ? rd_addr[3:0] - 4'd1 : rd_addr[3:0];
    assign wslot   = (wa[3:0] > 4'd6) ? wa[3:0] - 4'd1 : wa[3:0];

    // Read decode, registered together with the memory read data.
    always_comb begin
        n_region = hbd_pkg::RG_ERR;
        n_rval   = 8'h00;
        priority if (rd_addr <= 16'h7FFF) begin
            priority if (r_overlay && rd_addr[15:8] == 8'h00) n_region = hbd_pkg::RG_BOOT;
            else if ({1'b0, rd_addr} < hbd_pkg::ROM_LIMIT) n_region = hbd_pkg::RG_CART;
            else begin
                n_region = hbd_pkg::RG_REG;
                n_rval   = 8'hFF;
            end
        end else if (rd_addr <= 16'h9FFF) n_region = hbd_pkg::RG_VRAM;
        else if (rd_addr <= 16'hBFFF) n_region = hbd_pkg::RG_ERR;
        else if (rd_addr <= 16'hFDFF) n_region = hbd_pkg::RG_WRAM;
        else if (rd_addr <= 16'hFE9F) n_region = hbd_pkg::RG_OAM;
        else if (rd_addr <= 16'hFEFF) n_region = hbd_pkg::RG_ERR;
        else if (rd_addr <= 16'hFF7F) begin
            n_region = hbd_pkg::RG_REG;
            priority if (rd_addr == 16'hFF00) n_rval = r_joy;
            else if (rd_addr == 16'hFF01) n_rval = 8'hFF;
            else if (rd_addr == 16'hFF02) n_rval = r_sc;
            else if (rd_addr >= 16'hFF04 && rd_addr <= 16'hFF07) n_rval = r_tmr[rd_addr[1:0]];
            else if (rd_addr == 16'hFF0F) n_rval = r_if;
            else if (rd_addr >= 16'hFF40 && rd_addr <= 16'hFF4B && rd_addr != hbd_pkg::ADDR_DMA)
                n_rval = r_lcd[rslot];
            else if (rd_addr == 16'hFF4D || rd_addr == hbd_pkg::ADDR_BOOT_OFF) n_rval = 8'hFF;
            else n_region = hbd_pkg::RG_ERR;
        end else if (rd_addr <= 16'hFFFE) n_region = hbd_pkg::RG_HRAM;
        else begin
            n_region = hbd_pkg::RG_REG;
            n_rval   = r_ie;
        end
    end

    always_comb begin
        unique case (r_region)
            hbd_pkg::RG_BOOT: rd_byte = r_boot_q;
            hbd_pkg::RG_CART: rd_byte = r_cart_q;
            hbd_pkg::RG_VRAM: rd_byte = r_vram_q;
            hbd_pkg::RG_WRAM: rd_byte = r_wram_q;
            hbd_pkg::RG_OAM:  rd_byte = r_oam_q;
            hbd_pkg::RG_HRAM: rd_byte = r_hram_q;
            hbd_pkg::RG_REG:  rd_byte = r_rval;
            hbd_pkg::RG_ERR:  rd_byte = 8'h00;
        endcase
    end
    assign rd_err = (r_region == hbd_pkg::RG_ERR);

    // Write decode of the captured request.
    always_comb begin
        {w_vram, w_wram, w_oam, w_hram, w_ie} = '0;
        {w_joy, w_sc, w_tmr, w_if, w_lcd, w_boot_off, w_err} = '0;
        priority if (wa <= 16'h7FFF) begin
        end else if (wa <= 16'h9FFF) w_vram = 1'b1;
        else if (wa <= 16'hBFFF) w_err = 1'b1;
        else if (wa <= 16'hFDFF) w_wram = 1'b1;
        else if (wa <= 16'hFE9F) w_oam = 1'b1;
        else if (wa <= 16'hFEFF) begin
        end else if (wa <= 16'hFF7F) begin
            priority if (wa == 16'hFF00) w_joy = 1'b1;
            else if (wa == 16'hFF01) begin
            end else if (wa == 16'hFF02) w_sc = 1'b1;
            else if (wa >= 16'hFF04 && wa <= 16'hFF07) w_tmr = 1'b1;
            else if (wa == 16'hFF0F) w_if = 1'b1;
            else if ((wa >= 16'hFF10 && wa <= 16'hFF26) || (wa >= 16'hFF30 && wa <= 16'hFF3F)
                     || wa == 16'hFF7F || wa == hbd_pkg::ADDR_DMA) begin
            end else if (wa >= 16'hFF40 && wa <= 16'hFF4B && wa != 16'hFF44) w_lcd = 1'b1;
            else if (wa == hbd_pkg::ADDR_BOOT_OFF) w_boot_off = 1'b1;
            else w_err = 1'b1;
        end else if (wa <= 16'hFFFE) w_hram = 1'b1;
        else w_ie = 1'b1;
    end

    always_comb begin
        pend    = r_if[4:0] & r_ie[4:0];
        irq_num = 3'd0;
        for (int i = 4; i >= 0; i--) begin
            if (pend[i]) irq_num = 3'(i);
        end
        taken = r_req.master_enable && (pend != 5'd0);
    end

    always_comb begin
        n_res = r_res;
        if (i_cmd.exec) begin
            n_res = '0;
            unique case (r_req.action)
                hbd_pkg::ACT_WRITE:   n_res.status = w_err;
                hbd_pkg::ACT_LD_CART: n_res.status = 1'b0;
                hbd_pkg::ACT_LD_BOOT: n_res.status = 1'b0;
                hbd_pkg::ACT_POLL: begin
                    n_res.wake       = r_req.cpu_halted && (pend != 5'd0);
                    n_res.irq_taken  = taken;
                    n_res.irq_vector = taken ? {1'b1, irq_num, 3'b000} : 7'd0;
                end
                default: n_res.status = 1'b1;
            endcase
        end else if (i_cmd.rd_done) begin
            n_res = '0;
            n_res.read_data = rd_byte;
            n_res.status    = rd_err;
        end else if (i_cmd.dma_wr && o_stat.dma_last) begin
            n_res = '0;
            n_res.status = r_dma_bad || rd_err;
        end
    end

    assign cart_we = i_cmd.exec && r_req.action == hbd_pkg::ACT_LD_CART
                     && {1'b0, wa} < hbd_pkg::ROM_LIMIT;
    assign boot_we = i_cmd.exec && r_req.action == hbd_pkg::ACT_LD_BOOT && wa[15:8] == 8'h00;
    assign vram_we = i_cmd.clr || (exec_wr && w_vram);
    assign vram_wa = i_cmd.clr ? r_clr : wa[CLR_W-1:0];
    assign vram_wd = i_cmd.clr ? 8'h00 : wd;
    assign wram_we = i_cmd.clr || (exec_wr && w_wram);
    assign wram_wa = i_cmd.clr ? r_clr : wa[CLR_W-1:0];
    assign wram_wd = i_cmd.clr ? 8'h00 : wd;
    assign hram_we = (i_cmd.clr && r_clr < CLR_W'(hbd_pkg::HRAM_BYTES)) || (exec_wr && w_hram);
    assign hram_wa = i_cmd.clr ? r_clr[6:0] : wa[6:0];
    assign hram_wd = i_cmd.clr ? 8'h00 : wd;
    assign oam_we  = (i_cmd.clr && r_clr < CLR_W'(hbd_pkg::OAM_BYTES)) || (exec_wr && w_oam)
                     || i_cmd.dma_wr;
    always_comb begin
        priority if (i_cmd.clr) begin
            oam_wa = r_clr[OAM_AW-1:0];
            oam_wd = 8'h00;
        end else if (i_cmd.dma_wr) begin
            oam_wa = r_dma_idx[OAM_AW-1:0];
            oam_wd = rd_err ? 8'h00 : rd_byte;
        end else begin
            oam_wa = wa[OAM_AW-1:0];
            oam_wd = wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cart_we) cart_mem[wa[hbd_pkg::CART_AW-1:0]] <= wd;
        r_cart_q <= cart_mem[rd_addr[hbd_pkg::CART_AW-1:0]];
    end
    always_ff @(posedge i_clk) begin
        if (boot_we) boot_mem[wa[7:0]] <= wd;
        r_boot_q <= boot_mem[rd_addr[7:0]];
    end
    always_ff @(posedge i_clk) begin
        if (vram_we) vram_mem[vram_wa] <= vram_wd;
        r_vram_q <= vram_mem[rd_addr[CLR_W-1:0]];
    end
    always_ff @(posedge i_clk) begin
        if (wram_we) wram_mem[wram_wa] <= wram_wd;
        r_wram_q <= wram_mem[rd_addr[CLR_W-1:0]];
    end
    always_ff @(posedge i_clk) begin
        if (oam_we) oam_mem[oam_wa] <= oam_wd;
        r_oam_q <= oam_mem[rd_addr[OAM_AW-1:0]];
    end
    always_ff @(posedge i_clk) begin
        if (hram_we) hram_mem[hram_wa] <= hram_wd;
        r_hram_q <= hram_mem[rd_addr[6:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) r_req <= i_req;
        if (i_cmd.rd || i_cmd.dma_rd) begin
            r_region <= n_region;
            r_rval   <= n_rval;
        end
        r_res <= n_res;
        if (i_cmd.out_load) r_out <= r_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_overlay <= 1'b1;
            r_joy     <= 8'h0F;
            r_sc      <= 8'h00;
            r_if      <= 8'h00;
            r_ie      <= 8'h00;
            r_tmr     <= '{default: 8'h00};
            r_lcd     <= '{default: 8'h00};
            r_clr     <= '0;
            r_dma_idx <= 8'h00;
            r_dma_bad <= 1'b0;
        end else begin
            if (i_cmd.clr) r_clr <= r_clr + CLR_W'(1);
            if (i_cmd.dma_start) begin
                r_dma_idx <= 8'h00;
                r_dma_bad <= 1'b0;
            end
            if (i_cmd.dma_wr) begin
                r_dma_idx <= r_dma_idx + 8'd1;
                r_dma_bad <= r_dma_bad || rd_err;
            end
            if (exec_wr) begin
                if (w_joy) r_joy <= {wd[7:4], r_joy[3:0]};
                if (w_sc)  r_sc  <= wd;
                if (w_tmr) r_tmr[wa[1:0]] <= (wa[1:0] == 2'd0) ? 8'h00 : wd;
                if (w_if)  r_if  <= wd;
                if (w_ie)  r_ie  <= wd;
                if (w_lcd) begin
                    r_lcd[wslot] <= (wa == 16'hFF41) ? {wd[7:3], r_lcd[wslot][2:0]} : wd;
                end
                if (w_boot_off && wd != 8'h00) r_overlay <= 1'b0;
            end
            if (i_cmd.exec && r_req.action == hbd_pkg::ACT_POLL && taken) begin
                r_if[irq_num] <= 1'b0;
            end
        end
    end

    assign o_stat.clr_last = (r_clr == {CLR_W{1'b1}});
    assign o_stat.is_read  = (r_req.action == hbd_pkg::ACT_READ);
    assign o_stat.is_dma   = (r_req.action == hbd_pkg::ACT_WRITE) && (wa == hbd_pkg::ADDR_DMA);
    assign o_stat.dma_last = (r_dma_idx == 8'(hbd_pkg::OAM_BYTES - 1));
    assign o_rsp = r_out;
endmodule
`default_nettype wire

>>> hdl/handheld_bus_decoder_io_regs.sv
// Top level of the bus decoder with I/O registers and OAM DMA.
//  channel | dir | handshake   | payload
//  i_req   | in  | valid/ready | action, address, write_data, cpu_halted, master_enable
//  o_rsp   | out | valid/ready | read_data, status, wake, irq_taken, irq_vector
// A read passes through the states EXEC, RDATA and FINISH, the other actions through EXEC and FINISH.
// A write to FF46 runs the OAM DMA loop, a read state and a write state for each byte.
// After reset a clearing pass zeroes the RAMs; ready stays low.
// A new request is taken while the previous result still waits on o_rsp.
`default_nettype none
module handheld_bus_decoder_io_regs (
    input wire logic i_clk,
    input wire logic i_rst_n,
    hbd_req_if.sink   i_req,
    hbd_rsp_if.source o_rsp
);
    hbd_pkg::t_cmd  cmd;
    hbd_pkg::t_stat stat;
    hbd_pkg::t_req  req;
    hbd_pkg::t_rsp  rsp;

    assign req.action        = i_req.action;
    assign req.address       = i_req.address;
    assign req.write_data    = i_req.write_data;
    assign req.cpu_halted    = i_req.cpu_halted;
    assign req.master_enable = i_req.master_enable;

    hbd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_out_ready (o_rsp.ready),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid)
    );

    hbd_datapath u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_req   (req),
        .o_stat  (stat),
        .o_rsp   (rsp)
    );

    assign o_rsp.read_data  = rsp.read_data;
    assign o_rsp.status     = rsp.status;
    assign o_rsp.wake       = rsp.wake;
    assign o_rsp.irq_taken  = rsp.irq_taken;
    assign o_rsp.irq_vector = rsp.irq_vector;
endmodule
`default_nettype wire

>>> hdl/hbd_checker.sv
// Port checker of the bus decoder and its bind to the top level.
`default_nettype none
`include "handheld_bus_decoder_io_regs_assert.svh"
module hbd_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_req_ready,
    input wire logic       i_rsp_valid,
    input wire logic       i_rsp_ready,
    input wire logic [7:0] i_read_data,
    input wire logic       i_status,
    input wire logic       i_irq_taken,
    input wire logic [6:0] i_irq_vector
);
    `HBD_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, i_rsp_valid, "response dropped while stalled")
    `HBD_ASSERT_IMPL(a_err_zero, i_clk, i_rst_n, i_rsp_valid && i_status, i_read_data == 8'h00, "error response carries data")
    `HBD_ASSERT_IMPL(a_vector, i_clk, i_rst_n, i_rsp_valid, i_irq_taken ? (i_irq_vector[6] && i_irq_vector[2:0] == 3'd0) : (i_irq_vector == 7'd0), "bad interrupt vector")
    `HBD_ASSERT_IMPL(a_rst_quiet, i_clk, i_rst_n, $past(!i_rst_n), !i_rsp_valid && !i_req_ready, "active right after reset")
endmodule

bind handheld_bus_decoder_io_regs hbd_checker u_hbd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_ready  (i_req.ready),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_read_data  (o_rsp.read_data),
    .i_status     (o_rsp.status),
    .i_irq_taken  (o_rsp.irq_taken),
    .i_irq_vector (o_rsp.irq_vector)
);
`default_nettype wire
